[hdl/plbu_pkg.sv]
// ----------------------------------------------------------------------------
// plbu_pkg
// Shared types and constants for the price level book update unit: level
// records, update commands and field widths.
// ----------------------------------------------------------------------------
package plbu_pkg;

    localparam int LEVELS_DEF = 64;
    localparam int PRICE_W    = 32;
    localparam int DELTA_W    = 32;
    localparam int TOTAL_W    = 40;

    // one price level as held in a cell
    typedef struct packed {
        logic                       valid;
        logic [PRICE_W-1:0]         price;
        logic signed [TOTAL_W-1:0]  total;
    } t_level;

    // update applied along the whole chain of one side
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_MODIFY = 2'd1,
        OP_REMOVE = 2'd2,
        OP_INSERT = 2'd3
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic [PRICE_W-1:0]         key;
        logic signed [DELTA_W-1:0]  delta;
    } t_cmd;

    // per-cell compare results captured when a transaction is accepted
    typedef struct packed {
        logic ahead;
        logic match;
        logic zero;
    } t_flags;

endpackage

[hdl/plbu_cell.sv]
// ----------------------------------------------------------------------------
// plbu_cell
// One slot of a sorted level chain. Compares a broadcast key with its own
// level, then keeps or modifies it, loads the inserted level, or takes its left or right neighbor's level.
// ----------------------------------------------------------------------------
module plbu_cell
    import plbu_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_descend,
    input  logic                       i_capture,
    input  logic [PRICE_W-1:0]         i_probe_key,
    input  logic signed [DELTA_W-1:0]  i_probe_delta,
    input  t_cmd                       i_cmd,
    input  t_level                     i_left,
    input  logic                       i_left_ahead,
    input  t_level                     i_right,
    output t_level                     o_level,
    output t_flags                     o_flags
);

    logic                       r_valid;
    logic [PRICE_W-1:0]         r_price;
    logic signed [TOTAL_W-1:0]  r_total;
    logic signed [TOTAL_W-1:0]  r_sum;
    t_flags                     r_flags;

    logic                       n_valid;
    logic [PRICE_W-1:0]         n_price;
    logic signed [TOTAL_W-1:0]  n_total;
    logic signed [TOTAL_W:0]    sum_wide;
    logic signed [TOTAL_W-1:0]  sum_sat;
    logic                       is_ahead;

    // saturating add of the probe delta to this level
    always_comb begin
        sum_wide = (TOTAL_W+1)'(r_total) + (TOTAL_W+1)'(i_probe_delta);
        if (sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1]) begin
            sum_sat = {sum_wide[TOTAL_W], {(TOTAL_W-1){~sum_wide[TOTAL_W]}}};
        end else begin
            sum_sat = sum_wide[TOTAL_W-1:0];
        end
    end

    // level sits strictly closer to the top of book than the key
    always_comb begin
        if (i_descend) begin
            is_ahead = r_valid && (r_price > i_probe_key);
        end else begin
            is_ahead = r_valid && (r_price < i_probe_key);
        end
    end

    // next level for the update step
    always_comb begin
        n_valid = r_valid;
        n_price = r_price;
        n_total = r_total;
        case (i_cmd.op)
            OP_MODIFY: begin
                if (r_flags.match) begin
                    n_total = r_sum;
                end
            end
            OP_REMOVE: begin
                if (!r_flags.ahead) begin
                    n_valid = i_right.valid;
                    n_price = i_right.price;
                    n_total = i_right.total;
                end
            end
            OP_INSERT: begin
                if (!r_flags.ahead) begin
                    if (i_left_ahead) begin
                        n_valid = 1'b1;
                        n_price = i_cmd.key;
                        n_total = TOTAL_W'(i_cmd.delta);
                    end else begin
                        n_valid = i_left.valid;
                        n_price = i_left.price;
                        n_total = i_left.total;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // level storage, valid bit cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_price <= n_price;
        r_total <= n_total;
    end

    // compare results held for the update step
    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_flags.ahead <= is_ahead;
            r_flags.match <= r_valid && (r_price == i_probe_key);
            r_flags.zero  <= (sum_sat == '0);
            r_sum         <= sum_sat;
        end
    end

    assign o_level.valid = r_valid;
    assign o_level.price = r_price;
    assign o_level.total = r_total;
    assign o_flags       = r_flags;

endmodule

[hdl/plbu_side.sv]
// ----------------------------------------------------------------------------
// plbu_side
// One side of the book: a chain of level cells kept sorted with the best
// level in cell 0, plus the decision of which update the chain performs.
// ----------------------------------------------------------------------------
module plbu_side
    import plbu_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
)(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_descend,
    input  logic                       i_capture,
    input  logic [PRICE_W-1:0]         i_probe_key,
    input  logic signed [DELTA_W-1:0]  i_probe_delta,
    input  logic                       i_update,
    input  logic [PRICE_W-1:0]         i_key,
    input  logic signed [DELTA_W-1:0]  i_delta,
    output t_level                     o_head,
    output logic                       o_overflow
);

    t_level          levels   [LEVELS];
    t_flags          flags    [LEVELS];
    t_level          left_lv  [LEVELS];
    t_level          right_lv [LEVELS];
    logic [LEVELS-1:0] left_ahead;
    logic [LEVELS-1:0] match_vec;
    logic [LEVELS-1:0] zero_hit_vec;
    logic            any_match;
    logic            zero_hit;
    logic            full;
    logic            want_insert;
    t_cmd            cmd;

    // neighbor wiring and cell row
    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        assign match_vec[g]    = flags[g].match;
        assign zero_hit_vec[g] = flags[g].match & flags[g].zero;

        if (g == 0) begin : g_first
            assign left_lv[g]    = '0;
            assign left_ahead[g] = 1'b1;
        end else begin : g_inner
            assign left_lv[g]    = levels[g-1];
            assign left_ahead[g] = flags[g-1].ahead;
        end

        if (g == LEVELS-1) begin : g_last
            assign right_lv[g] = '0;
        end else begin : g_body
            assign right_lv[g] = levels[g+1];
        end

        plbu_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_descend     (i_descend),
            .i_capture     (i_capture),
            .i_probe_key   (i_probe_key),
            .i_probe_delta (i_probe_delta),
            .i_cmd         (cmd),
            .i_left        (left_lv[g]),
            .i_left_ahead  (left_ahead[g]),
            .i_right       (right_lv[g]),
            .o_level       (levels[g]),
            .o_flags       (flags[g])
        );
    end

    // chain-wide update decision
    assign any_match   = |match_vec;
    assign zero_hit    = |zero_hit_vec;
    assign full        = levels[LEVELS-1].valid;
    assign want_insert = i_update && !any_match && (i_delta != '0);

    always_comb begin
        cmd.key   = i_key;
        cmd.delta = i_delta;
        cmd.op    = OP_NONE;
        if (i_update && any_match) begin
            cmd.op = zero_hit ? OP_REMOVE : OP_MODIFY;
        end else if (want_insert && !full) begin
            cmd.op = OP_INSERT;
        end
    end

    assign o_overflow = want_insert && full;
    assign o_head     = levels[0];

endmodule

[hdl/price_level_book_update_unit.sv]
// ----------------------------------------------------------------------------
// price_level_book_update_unit
// Two-sided price level book with aggregated sizes and top-of-book report.
// ----------------------------------------------------------------------------
// An update transaction is taken on the clock edge where start is high and
// busy is low: i_is_sell picks the side, i_price the level and
// i_size_delta the signed change. busy stays high after the accept while
// the update pass runs along the cell chain of the selected side, so a new
// transaction is not taken until that pass is done.
// Each side is a chain of LEVELS cells sorted best-first (bids descending,
// asks ascending). The accept edge captures every cell's compare and
// saturating sum; the next edge shifts, modifies or inserts along the chain.
// The result is driven for exactly one cycle with o_valid high, once the
// update pass is done and the emit step has sampled both chain heads. It
// carries best bid and best ask with their sizes, the not-crossed flag and
// the overflow flag of this update. The receiver cannot stall: every result
// is taken in its strobe cycle. Reset (i_rst_n low, synchronous) empties both
// tables and clears busy and o_valid; level contents are not cleared.
// ----------------------------------------------------------------------------
module price_level_book_update_unit
    import plbu_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
)(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_is_sell,
    input  logic [PRICE_W-1:0]          i_price,
    input  logic signed [DELTA_W-1:0]   i_size_delta,
    output logic                        o_valid,
    output logic                        o_bid_present,
    output logic [PRICE_W-1:0]          o_best_bid_price,
    output logic signed [TOTAL_W-1:0]   o_best_bid_size,
    output logic                        o_ask_present,
    output logic [PRICE_W-1:0]          o_best_ask_price,
    output logic signed [TOTAL_W-1:0]   o_best_ask_size,
    output logic                        o_not_crossed,
    output logic                        o_table_overflow
);

    logic                       r_busy;
    logic                       r_emit;
    logic                       r_is_sell;
    logic [PRICE_W-1:0]         r_key;
    logic signed [DELTA_W-1:0]  r_delta;
    logic                       r_ovf;
    logic                       r_valid;
    logic                       r_bid_present;
    logic [PRICE_W-1:0]         r_bid_price;
    logic signed [TOTAL_W-1:0]  r_bid_size;
    logic                       r_ask_present;
    logic [PRICE_W-1:0]         r_ask_price;
    logic signed [TOTAL_W-1:0]  r_ask_size;
    logic                       r_not_crossed;
    logic                       r_table_overflow;

    logic                       accept;
    t_level                     bid_head;
    t_level                     ask_head;
    logic                       bid_ovf;
    logic                       ask_ovf;

    assign accept = start && !r_busy;

    // bid chain, best level is the highest price
    plbu_side #(.LEVELS(LEVELS)) u_bid (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_descend     (1'b1),
        .i_capture     (accept),
        .i_probe_key   (i_price),
        .i_probe_delta (i_size_delta),
        .i_update      (r_busy && !r_is_sell),
        .i_key         (r_key),
        .i_delta       (r_delta),
        .o_head        (bid_head),
        .o_overflow    (bid_ovf)
    );

    // ask chain, best level is the lowest price
    plbu_side #(.LEVELS(LEVELS)) u_ask (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_descend     (1'b0),
        .i_capture     (accept),
        .i_probe_key   (i_price),
        .i_probe_delta (i_size_delta),
        .i_update      (r_busy && r_is_sell),
        .i_key         (r_key),
        .i_delta       (r_delta),
        .o_head        (ask_head),
        .o_overflow    (ask_ovf)
    );

    // transaction sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_emit  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= accept;
            r_emit  <= r_busy;
            r_valid <= r_emit;
        end
    end

    // held transaction fields and overflow of the update pass
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_sell <= i_is_sell;
            r_key     <= i_price;
            r_delta   <= i_size_delta;
        end
        if (r_busy) begin
            r_ovf <= r_is_sell ? ask_ovf : bid_ovf;
        end
    end

    // top-of-book result registers
    always_ff @(posedge i_clk) begin
        if (r_emit) begin
            r_bid_present    <= bid_head.valid;
            r_bid_price      <= bid_head.valid ? bid_head.price : '0;
            r_bid_size       <= bid_head.valid ? bid_head.total : '0;
            r_ask_present    <= ask_head.valid;
            r_ask_price      <= ask_head.valid ? ask_head.price : '0;
            r_ask_size       <= ask_head.valid ? ask_head.total : '0;
            r_not_crossed    <= !(bid_head.valid && ask_head.valid &&
                                  (bid_head.price > ask_head.price));
            r_table_overflow <= r_ovf;
        end
    end

    assign busy             = r_busy;
    assign o_valid          = r_valid;
    assign o_bid_present    = r_bid_present;
    assign o_best_bid_price = r_bid_price;
    assign o_best_bid_size  = r_bid_size;
    assign o_ask_present    = r_ask_present;
    assign o_best_ask_price = r_ask_price;
    assign o_best_ask_size  = r_ask_size;
    assign o_not_crossed    = r_not_crossed;
    assign o_table_overflow = r_table_overflow;

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the price level book update unit.
// ----------------------------------------------------------------------------
// Updates are driven at the falling edge and taken when start is high and
// busy is low. A bench-side copy of both sorted level tables predicts the
// top of book for each accepted update. A monitor compares every strobed
// result field by field with the oldest prediction. The tests are a short
// directed pass, full-table overflow on each side, saturation of a level
// total at both rails, and a random mix mostly over a narrow band of prices.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plbu_pkg::*;

    localparam int      CLK_HALF       = 10;
    localparam int      RESET_CYCLES   = 5;
    localparam int      WATCHDOG_LIMIT = 1000;
    localparam int      DRAIN_CYCLES   = 4;
    localparam bit      SIDE_BID       = 1'b0;
    localparam bit      SIDE_ASK       = 1'b1;
    localparam logic signed [DELTA_W-1:0] DELTA_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DELTA_W-1:0] DELTA_MIN = 32'sh8000_0000;
    localparam longint  TOTAL_MAX      = 64'sd549755813887;
    localparam longint  TOTAL_MIN      = -64'sd549755813888;
    localparam logic [PRICE_W-1:0] MIX_BASE = 32'h0001_0000;

    // expected top of book for one update
    typedef struct packed {
        logic                       bid_present;
        logic [PRICE_W-1:0]         bid_price;
        logic signed [TOTAL_W-1:0]  bid_size;
        logic                       ask_present;
        logic [PRICE_W-1:0]         ask_price;
        logic signed [TOTAL_W-1:0]  ask_size;
        logic                       not_crossed;
        logic                       overflow;
    } t_book_top;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic                       i_is_sell;
    logic [PRICE_W-1:0]         i_price;
    logic signed [DELTA_W-1:0]  i_size_delta;
    logic                       o_valid;
    logic                       o_bid_present;
    logic [PRICE_W-1:0]         o_best_bid_price;
    logic signed [TOTAL_W-1:0]  o_best_bid_size;
    logic                       o_ask_present;
    logic [PRICE_W-1:0]         o_best_ask_price;
    logic signed [TOTAL_W-1:0]  o_best_ask_size;
    logic                       o_not_crossed;
    logic                       o_table_overflow;

    // bench copy of both tables, prices ascending, index 0 bid / 1 ask
    logic [PRICE_W-1:0] lvl_price [2][LEVELS_DEF];
    longint             lvl_total [2][LEVELS_DEF];
    int                 lvl_count [2];

    t_book_top          book_expect_q [$];
    t_book_top          want;
    int                 err_count;
    int                 n_sent;
    int                 n_checked;
    int                 n_overflow;
    int                 n_crossed;
    int                 idle_cycles;
    bit                 quiet;

    price_level_book_update_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_is_sell        (i_is_sell),
        .i_price          (i_price),
        .i_size_delta     (i_size_delta),
        .o_valid          (o_valid),
        .o_bid_present    (o_bid_present),
        .o_best_bid_price (o_best_bid_price),
        .o_best_bid_size  (o_best_bid_size),
        .o_ask_present    (o_ask_present),
        .o_best_ask_price (o_best_ask_price),
        .o_best_ask_size  (o_best_ask_size),
        .o_not_crossed    (o_not_crossed),
        .o_table_overflow (o_table_overflow)
    );

    // clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // position of a price in one table, -1 when absent
    function automatic int level_index(bit side, logic [PRICE_W-1:0] key);
        for (int i = 0; i < lvl_count[side]; i++) begin
            if (lvl_price[side][i] == key) return i;
        end
        return -1;
    endfunction

    // random price not yet held on that side
    function automatic logic [PRICE_W-1:0] fresh_price(bit side);
        logic [PRICE_W-1:0] p;
        p = $urandom;
        while (level_index(side, p) >= 0) p = $urandom;
        return p;
    endfunction

    // add a change to one level; returns 1 when a new level was dropped
    function automatic bit book_apply(bit side, logic [PRICE_W-1:0] key,
                                      logic signed [DELTA_W-1:0] delta);
        int     n;
        int     pos;
        longint s;
        n   = lvl_count[side];
        pos = 0;
        while (pos < n && lvl_price[side][pos] < key) pos++;
        // existing level: saturating add, removal on zero
        if (pos < n && lvl_price[side][pos] == key) begin
            s = lvl_total[side][pos] + longint'(delta);
            if (s > TOTAL_MAX) s = TOTAL_MAX;
            if (s < TOTAL_MIN) s = TOTAL_MIN;
            if (s == 0) begin
                for (int i = pos; i + 1 < n; i++) begin
                    lvl_price[side][i] = lvl_price[side][i+1];
                    lvl_total[side][i] = lvl_total[side][i+1];
                end
                lvl_count[side] = n - 1;
            end else begin
                lvl_total[side][pos] = s;
            end
            return 1'b0;
        end
        // new level
        if (delta == 0) return 1'b0;
        if (n >= LEVELS_DEF) return 1'b1;
        for (int i = n; i > pos; i--) begin
            lvl_price[side][i] = lvl_price[side][i-1];
            lvl_total[side][i] = lvl_total[side][i-1];
        end
        lvl_price[side][pos] = key;
        lvl_total[side][pos] = longint'(delta);
        lvl_count[side]      = n + 1;
        return 1'b0;
    endfunction

    // best bid is the highest bid price, best ask the lowest ask price
    function automatic t_book_top book_top(bit ovf);
        t_book_top r;
        int        nb;
        r  = '0;
        nb = lvl_count[SIDE_BID];
        if (nb > 0) begin
            r.bid_present = 1'b1;
            r.bid_price   = lvl_price[SIDE_BID][nb-1];
            r.bid_size    = TOTAL_W'(lvl_total[SIDE_BID][nb-1]);
        end
        if (lvl_count[SIDE_ASK] > 0) begin
            r.ask_present = 1'b1;
            r.ask_price   = lvl_price[SIDE_ASK][0];
            r.ask_size    = TOTAL_W'(lvl_total[SIDE_ASK][0]);
        end
        r.not_crossed = !(r.bid_present && r.ask_present && r.bid_price > r.ask_price);
        r.overflow    = ovf;
        return r;
    endfunction

    // drive one update transaction and record its prediction
    task automatic send_update(input bit side, input logic [PRICE_W-1:0] key,
                               input logic signed [DELTA_W-1:0] delta);
        int        gap;
        bit        ovf;
        t_book_top top;
        if (!quiet && $urandom_range(99) < 18) begin
            gap = $urandom_range(3, 1);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_is_sell    <= side;
        i_price      <= key;
        i_size_delta <= delta;
        do @(posedge i_clk); while (busy);
        ovf = book_apply(side, key, delta);
        top = book_top(ovf);
        book_expect_q.push_back(top);
        n_sent++;
        if (ovf) n_overflow++;
        if (!top.not_crossed) n_crossed++;
    endtask

    // bring a level to zero, in more than one step when its total is wide
    task automatic clear_level(input bit side, input logic [PRICE_W-1:0] key);
        int     idx;
        longint t;
        logic signed [DELTA_W-1:0] d;
        idx = level_index(side, key);
        while (idx >= 0) begin
            t = lvl_total[side][idx];
            if (-t > longint'(DELTA_MAX)) d = DELTA_MAX;
            else if (-t < longint'(DELTA_MIN)) d = DELTA_MIN;
            else d = DELTA_W'(-t);
            send_update(side, key, d);
            idx = level_index(side, key);
        end
    endtask

    // one field of a result
    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            err_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (book_expect_q.size() == 0) begin
                $error("result strobed with no update outstanding");
                err_count++;
            end else begin
                want = book_expect_q.pop_front();
                check_field("bid_present",    64'(want.bid_present), 64'(o_bid_present));
                check_field("best_bid_price", 64'(want.bid_price),   64'(o_best_bid_price));
                check_field("best_bid_size",  64'(want.bid_size),    64'(o_best_bid_size));
                check_field("ask_present",    64'(want.ask_present), 64'(o_ask_present));
                check_field("best_ask_price", 64'(want.ask_price),   64'(o_best_ask_price));
                check_field("best_ask_size",  64'(want.ask_size),    64'(o_best_ask_size));
                check_field("not_crossed",    64'(want.not_crossed), 64'(o_not_crossed));
                check_field("table_overflow", 64'(want.overflow),    64'(o_table_overflow));
                n_checked++;
            end
        end
    end

    // watchdog on cycles with no transaction and no result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // creation, removal, crossing and field extremes
    task automatic test_directed_book();
        send_update(SIDE_BID, 32'd500, 32'sd0);
        send_update(SIDE_ASK, 32'd0, 32'sd0);
        send_update(SIDE_BID, 32'd500, 32'sd100);
        send_update(SIDE_BID, 32'd400, -32'sd50);
        send_update(SIDE_BID, 32'd600, 32'sd7);
        send_update(SIDE_ASK, 32'd700, 32'sd30);
        send_update(SIDE_ASK, 32'd600, 32'sd1);
        send_update(SIDE_ASK, 32'd550, 32'sd2);
        send_update(SIDE_BID, 32'd600, -32'sd7);
        send_update(SIDE_BID, 32'd500, 32'sd0);
        send_update(SIDE_BID, 32'd0, DELTA_MAX);
        send_update(SIDE_ASK, 32'hFFFF_FFFF, DELTA_MIN);
        send_update(SIDE_ASK, 32'd550, -32'sd2);
        send_update(SIDE_BID, 32'hFFFF_FFFF, 32'sd1);
        send_update(SIDE_BID, 32'hFFFF_FFFF, -32'sd1);
        send_update(SIDE_BID, 32'd400, 32'sd50);
        send_update(SIDE_ASK, 32'd600, -32'sd1);
        send_update(SIDE_ASK, 32'd700, -32'sd30);
        send_update(SIDE_ASK, 32'hFFFF_FFFF, DELTA_MAX);
        send_update(SIDE_ASK, 32'hFFFF_FFFF, 32'sd1);
        send_update(SIDE_BID, 32'd500, -32'sd100);
        send_update(SIDE_BID, 32'd0, DELTA_MIN + 32'sd1);
    endtask

    // fill one side, hit it with new prices, then drain it
    task automatic test_table_full(input bit side);
        int idx;
        logic signed [DELTA_W-1:0] d;
        for (int k = 0; k < LEVELS_DEF; k++) begin
            d = $urandom;
            if (d == 0) d = 32'sd1;
            send_update(side, fresh_price(side), d);
        end
        // new prices are dropped, a zero change is not an overflow
        send_update(side, fresh_price(side), 32'sd5);
        send_update(side, fresh_price(side), -32'sd1);
        send_update(side, fresh_price(side), 32'sd0);
        // existing levels still take changes
        idx = $urandom_range(LEVELS_DEF - 1);
        d   = (lvl_total[side][idx] == -1) ? 32'sd2 : 32'sd1;
        send_update(side, lvl_price[side][idx], d);
        // free one slot, refill it, overflow again
        clear_level(side, lvl_price[side][$urandom_range(LEVELS_DEF - 1)]);
        send_update(side, fresh_price(side), 32'sd9);
        send_update(side, fresh_price(side), 32'sd9);
        while (lvl_count[side] > 0)
            clear_level(side, lvl_price[side][$urandom_range(lvl_count[side] - 1)]);
    endtask

    // drive one bid level to the top rail and one ask level to the bottom
    task automatic test_saturation();
        logic [PRICE_W-1:0] bid_key;
        logic [PRICE_W-1:0] ask_key;
        bid_key = $urandom_range(100, 1);
        ask_key = $urandom_range(32'hFFFF_FFF0, 32'hFFFF_0000);
        for (int k = 0; k < 262; k++) begin
            quiet = (k < 100);
            send_update(SIDE_BID, bid_key, DELTA_MAX - $urandom_range(500));
            send_update(SIDE_ASK, ask_key, DELTA_MIN + $urandom_range(500));
        end
        quiet = 1'b0;
        // step back off both rails
        send_update(SIDE_BID, bid_key, DELTA_MIN);
        send_update(SIDE_ASK, ask_key, DELTA_MAX);
    endtask

    // random updates, mostly over a narrow band so levels meet, cross and empty
    task automatic test_random_mix(input int count);
        int  pick;
        int  idx;
        bit  side;
        logic [PRICE_W-1:0]        key;
        logic signed [DELTA_W-1:0] d;
        for (int k = 0; k < count; k++) begin
            quiet = (k < 40);
            side  = $urandom_range(1);
            pick  = $urandom_range(99);
            key   = MIX_BASE + $urandom_range(40);
            d     = $urandom_range(500, 1);
            if ($urandom_range(1)) d = -d;
            if (pick < 45) begin
                send_update(side, key, d);
            end else if (pick < 65) begin
                idx = (lvl_count[side] > 0) ? $urandom_range(lvl_count[side] - 1) : -1;
                if (idx >= 0 && lvl_total[side][idx] < 64'sd4294967296
                        && lvl_total[side][idx] > -64'sd4294967296)
                    clear_level(side, lvl_price[side][idx]);
                else
                    send_update(side, key, d);
            end else if (pick < 75) begin
                send_update(side, key, 32'sd0);
            end else if (pick < 90) begin
                send_update(side, key, $urandom);
            end else begin
                send_update(side, $urandom, $urandom);
            end
        end
        quiet = 1'b0;
    endtask

    // test sequence
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_is_sell    = 1'b0;
        i_price      = '0;
        i_size_delta = '0;
        quiet        = 1'b0;
        err_count    = 0;
        n_sent       = 0;
        n_checked    = 0;
        n_overflow   = 0;
        n_crossed    = 0;
        idle_cycles  = 0;
        lvl_count[SIDE_BID] = 0;
        lvl_count[SIDE_ASK] = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_book();
        test_table_full(SIDE_BID);
        test_table_full(SIDE_ASK);
        test_saturation();
        test_random_mix(100);

        @(negedge i_clk);
        start <= 1'b0;
        while (book_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d book updates, %0d results checked", n_sent, n_checked);
        $display("including %0d dropped on a full table and %0d crossed books",
                 n_overflow, n_crossed);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[files.f]
hdl/plbu_pkg.sv
hdl/plbu_cell.sv
hdl/plbu_side.sv
hdl/price_level_book_update_unit.sv
tb/sv/tb_top.sv
